[hw/rtl/crc_pkg.sv]
// Package for the clipped rectangle copy address generator.
// Holds widths, codes, stage payload types and the map side limit.
// No dependencies.
package crc_pkg;

  localparam int FIELD_W  = 16;
  localparam int COORD_W  = 18;
  localparam int SIDE_W   = 11;
  localparam int CNT_W    = 11;
  localparam int IDX_W    = 20;
  localparam int MAX_SIDE = 1024;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PAIR = 2'd1,
    KIND_IDLE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_DST_WIDTH  = 2'd0,
    REG_DST_HEIGHT = 2'd1,
    REG_SRC_WIDTH  = 2'd2,
    REG_SRC_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    action_t                    action;
    logic signed [FIELD_W-1:0]  dest_x;
    logic signed [FIELD_W-1:0]  dest_y;
    logic signed [FIELD_W-1:0]  src_x;
    logic signed [FIELD_W-1:0]  src_y;
    logic signed [FIELD_W-1:0]  copy_w;
    logic signed [FIELD_W-1:0]  copy_h;
  } in_item_t;

  // a = map being clipped against, b = the other map
  typedef struct packed {
    action_t action;
    logic    reject;
    coord_t  ax;
    coord_t  ay;
    coord_t  bx;
    coord_t  by;
    coord_t  w;
    coord_t  h;
  } rect_t;

  typedef struct packed {
    action_t          action;
    logic             ok;
    logic [IDX_W-1:0] src_idx;
    logic [IDX_W-1:0] dst_idx;
    logic [CNT_W-1:0] w;
    logic [CNT_W-1:0] h;
  } start_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] src_index;
    logic [IDX_W-1:0] dst_index;
    logic             last;
  } result_t;

  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] r);
    logic [SIDE_W-1:0] lim;
    lim = SIDE_W'(MAX_SIDE);
    return (r > lim) ? lim : r;
  endfunction

  function automatic coord_t side_coord(input logic [SIDE_W-1:0] s);
    return $signed({{(COORD_W-SIDE_W){1'b0}}, s});
  endfunction

endpackage

[hw/rtl/crc_clip.sv]
// Clips a rectangle against one map: left, right, top, bottom.
// Shifts the other map's corner along with the clipped corner.
// Depends on crc_pkg.
module crc_clip
  import crc_pkg::*;
(
  input  rect_t             in_rect,
  input  logic [SIDE_W-1:0] map_w,
  input  logic [SIDE_W-1:0] map_h,
  output rect_t             out_rect
);

  coord_t pw;
  coord_t ph;
  coord_t ax;
  coord_t ay;
  coord_t bx;
  coord_t by;
  coord_t w;
  coord_t h;

  assign pw = side_coord(map_w);
  assign ph = side_coord(map_h);

  always_comb begin
    out_rect = in_rect;
    ax = in_rect.ax;
    ay = in_rect.ay;
    bx = in_rect.bx;
    by = in_rect.by;
    w  = in_rect.w;
    h  = in_rect.h;
    if (!in_rect.reject) begin
      if (ax >= pw || ay >= ph) begin
        out_rect.reject = 1'b1;
      end else begin
        if (ax < 0) begin
          bx = bx - ax;
          w  = w + ax;
          ax = '0;
        end
        if (ax + w > pw) begin
          w = pw - ax;
        end
        if (ay < 0) begin
          by = by - ay;
          h  = h + ay;
          ay = '0;
        end
        if (ay + h > ph) begin
          h = ph - ay;
        end
        out_rect.ax = ax;
        out_rect.ay = ay;
        out_rect.bx = bx;
        out_rect.by = by;
        out_rect.w  = w;
        out_rect.h  = h;
      end
    end
  end

endmodule

[hw/rtl/crc_index.sv]
// Final acceptance check and first index pair of a clipped rectangle.
// Takes the source-clipped rectangle (a = source, b = target). Depends on crc_pkg.
module crc_index
  import crc_pkg::*;
(
  input  rect_t             in_rect,
  input  logic [SIDE_W-1:0] src_w,
  input  logic [SIDE_W-1:0] dst_w,
  input  logic [SIDE_W-1:0] dst_h,
  output start_t            out_start
);

  logic [2*SIDE_W-1:0] src_prod;
  logic [2*SIDE_W-1:0] dst_prod;

  assign src_prod = in_rect.ay[SIDE_W-1:0] * src_w;
  assign dst_prod = in_rect.by[SIDE_W-1:0] * dst_w;

  always_comb begin
    out_start.action  = in_rect.action;
    out_start.ok      = !in_rect.reject
                        && !(in_rect.bx >= side_coord(dst_w))
                        && !(in_rect.by >= side_coord(dst_h))
                        && (in_rect.w > 0) && (in_rect.h > 0);
    out_start.src_idx = IDX_W'(src_prod) + IDX_W'(in_rect.ax[SIDE_W-1:0]);
    out_start.dst_idx = IDX_W'(dst_prod) + IDX_W'(in_rect.bx[SIDE_W-1:0]);
    out_start.w       = in_rect.w[CNT_W-1:0];
    out_start.h       = in_rect.h[CNT_W-1:0];
  end

endmodule

[hw/rtl/crc_run.sv]
// Run state of the copy: row and column counters and the index pointers.
// Turns start and advance items into results. Depends on crc_pkg.
module crc_run
  import crc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  start_t            item,
  input  logic [SIDE_W-1:0] src_w,
  input  logic [SIDE_W-1:0] dst_w,
  output result_t           res
);

  logic             run_active;
  logic             run_active_next;
  logic [CNT_W-1:0] col_left;
  logic [CNT_W-1:0] col_left_next;
  logic [CNT_W-1:0] rows_left;
  logic [CNT_W-1:0] rows_left_next;
  logic [CNT_W-1:0] run_width;
  logic [CNT_W-1:0] run_width_next;
  logic [IDX_W-1:0] src_ptr;
  logic [IDX_W-1:0] src_ptr_next;
  logic [IDX_W-1:0] dst_ptr;
  logic [IDX_W-1:0] dst_ptr_next;
  logic             pair;

  always_comb begin
    run_active_next = run_active;
    col_left_next   = col_left;
    rows_left_next  = rows_left;
    run_width_next  = run_width;
    src_ptr_next    = src_ptr;
    dst_ptr_next    = dst_ptr;
    pair            = 1'b0;
    res.kind        = KIND_IDLE;
    if (item.action == ACT_START) begin
      run_active_next = 1'b0;
      res.kind        = KIND_NONE;
      if (item.ok) begin
        src_ptr_next   = item.src_idx;
        dst_ptr_next   = item.dst_idx;
        run_width_next = item.w;
        col_left_next  = item.w - CNT_W'(1);
        rows_left_next = item.h - CNT_W'(1);
        pair           = 1'b1;
      end
    end else if (run_active) begin
      pair = 1'b1;
      if (col_left != '0) begin
        src_ptr_next  = src_ptr + IDX_W'(1);
        dst_ptr_next  = dst_ptr + IDX_W'(1);
        col_left_next = col_left - CNT_W'(1);
      end else begin
        src_ptr_next   = src_ptr + IDX_W'(src_w) - IDX_W'(run_width) + IDX_W'(1);
        dst_ptr_next   = dst_ptr + IDX_W'(dst_w) - IDX_W'(run_width) + IDX_W'(1);
        rows_left_next = rows_left - CNT_W'(1);
        col_left_next  = run_width - CNT_W'(1);
      end
    end
    if (pair) begin
      run_active_next = (col_left_next != '0) || (rows_left_next != '0);
      res.kind        = KIND_PAIR;
    end
    res.src_index = pair ? src_ptr_next : '0;
    res.dst_index = pair ? dst_ptr_next : '0;
    res.last      = pair && !run_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      col_left   <= '0;
      rows_left  <= '0;
      run_width  <= '0;
      src_ptr    <= '0;
      dst_ptr    <= '0;
    end else if (fire) begin
      run_active <= run_active_next;
      col_left   <= col_left_next;
      rows_left  <= rows_left_next;
      run_width  <= run_width_next;
      src_ptr    <= src_ptr_next;
      dst_ptr    <= dst_ptr_next;
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    run_active |-> (col_left < run_width))
    else $error("column counter outside run width");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (fire && res.last) |=> !run_active)
    else $error("run still active after last pair");

  a_idle_no_state_change: assert property (@(posedge clk) disable iff (rst)
    (fire && res.kind == KIND_IDLE) |=> !run_active && $stable(src_ptr))
    else $error("idle result changed run state");

endmodule

[hw/rtl/clipped_rect_copy_addr_gen.sv]
// Clipped rectangle copy address generator, top level.
// Holds the map size registers and the pipeline; uses crc_pkg, crc_clip,
// crc_index and crc_run.
//
// Each input item gives exactly one result item. The block accepts one item
// per clock cycle while s_axis_tready is high; its result passes through the
// input register, target clip, source clip, index multiply, then the run stage
// that owns the row/column counters and writes the output register. Advance
// items depend on the run state left by the item before them; that state is
// updated in the single run stage, so items of any mix still stream at one per
// cycle while the output takes them. Stalls on the output side fill the
// pipeline bubbles before holding off the input.
module clipped_rect_copy_addr_gen
  import crc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // dest_x[15:0], dest_y[31:16], src_x[47:32], src_y[63:48],
  // copy_w[79:64], copy_h[95:80]
  input  logic [95:0]      s_axis_tdata,
  // action[0]
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // src_index[19:0], dst_index[39:20]
  output logic [39:0]      m_axis_tdata,
  // kind[1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [SIDE_W-1:0] cfg_data
);

  logic [SIDE_W-1:0] dst_width;
  logic [SIDE_W-1:0] dst_height;
  logic [SIDE_W-1:0] src_width;
  logic [SIDE_W-1:0] src_height;
  logic [SIDE_W-1:0] dw;
  logic [SIDE_W-1:0] dh;
  logic [SIDE_W-1:0] sw;
  logic [SIDE_W-1:0] sh;

  logic     v0, v1, v2, v3, vo;
  logic     rdy0, rdy1, rdy2, rdy3, rdy4;
  in_item_t s0;
  rect_t    s1;
  rect_t    s2;
  start_t   s3;
  result_t  so;

  rect_t    tgt_in;
  rect_t    tgt_out;
  rect_t    src_in;
  rect_t    src_out;
  start_t   start;
  result_t  res;
  logic     fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_width  <= SIDE_W'(1);
      dst_height <= SIDE_W'(1);
      src_width  <= SIDE_W'(1);
      src_height <= SIDE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DST_WIDTH:  dst_width  <= cfg_data;
        REG_DST_HEIGHT: dst_height <= cfg_data;
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
      endcase
    end
  end

  assign dw = side_of(dst_width);
  assign dh = side_of(dst_height);
  assign sw = side_of(src_width);
  assign sh = side_of(src_height);

  assign rdy4 = !vo || m_axis_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign s_axis_tready = rdy0;
  assign fire = v3 && rdy4;

  always_comb begin
    tgt_in.action = s0.action;
    tgt_in.reject = 1'b0;
    tgt_in.ax     = COORD_W'(s0.dest_x);
    tgt_in.ay     = COORD_W'(s0.dest_y);
    tgt_in.bx     = COORD_W'(s0.src_x);
    tgt_in.by     = COORD_W'(s0.src_y);
    tgt_in.w      = COORD_W'(s0.copy_w);
    tgt_in.h      = COORD_W'(s0.copy_h);
  end

  crc_clip u_clip_tgt (
    .in_rect  (tgt_in),
    .map_w    (dw),
    .map_h    (dh),
    .out_rect (tgt_out)
  );

  always_comb begin
    src_in    = s1;
    src_in.ax = s1.bx;
    src_in.ay = s1.by;
    src_in.bx = s1.ax;
    src_in.by = s1.ay;
  end

  crc_clip u_clip_src (
    .in_rect  (src_in),
    .map_w    (sw),
    .map_h    (sh),
    .out_rect (src_out)
  );

  crc_index u_index (
    .in_rect   (s2),
    .src_w     (sw),
    .dst_w     (dw),
    .dst_h     (dh),
    .out_start (start)
  );

  crc_run u_run (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .item  (s3),
    .src_w (sw),
    .dst_w (dw),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy0) v0 <= s_axis_tvalid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && s_axis_tvalid) begin
      s0.action <= action_t'(s_axis_tuser);
      s0.dest_x <= s_axis_tdata[15:0];
      s0.dest_y <= s_axis_tdata[31:16];
      s0.src_x  <= s_axis_tdata[47:32];
      s0.src_y  <= s_axis_tdata[63:48];
      s0.copy_w <= s_axis_tdata[79:64];
      s0.copy_h <= s_axis_tdata[95:80];
    end
    if (rdy1 && v0) s1 <= tgt_out;
    if (rdy2 && v1) s2 <= src_out;
    if (rdy3 && v2) s3 <= start;
    if (fire)       so <= res;
  end

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = {so.dst_index, so.src_index};
  assign m_axis_tuser  = so.kind;
  assign m_axis_tlast  = so.last;

  a_last_is_pair: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_PAIR))
    else $error("last flag on a result without an index pair");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input held off while output side is free");

endmodule

[verif/clipped_rect_copy_addr_gen_tb.sv]
// Self-checking testbench for clipped_rect_copy_addr_gen: a directed plan, then
// random start/advance runs under several map sizes, idling and stall patterns.
// Depends on crc_pkg and the clipped_rect_copy_addr_gen RTL only.
module clipped_rect_copy_addr_gen_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crc_pkg::*;

  localparam int LATENCY         = 5;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int HOLD_CYCLES     = 120;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [95:0]      s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [39:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [SIDE_W-1:0] cfg_data = '0;

  clipped_rect_copy_addr_gen dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // map sizes as written, and the copy run as the block should track it
  logic [SIDE_W-1:0] map_dst_w = SIDE_W'(1);
  logic [SIDE_W-1:0] map_dst_h = SIDE_W'(1);
  logic [SIDE_W-1:0] map_src_w = SIDE_W'(1);
  logic [SIDE_W-1:0] map_src_h = SIDE_W'(1);
  bit                run_on = 1'b0;
  logic [CNT_W-1:0]  cols_to_go = '0;
  logic [CNT_W-1:0]  rows_to_go = '0;
  logic [CNT_W-1:0]  row_len = '0;
  logic [IDX_W-1:0]  src_at = '0;
  logic [IDX_W-1:0]  dst_at = '0;

  result_t pending_pairs[$];
  int      errors = 0;
  int      cycles = 0;
  int      tx_idle_pct = 30;
  int      rx_idle_pct = 63;
  int      rx_hold = 0;

  typedef struct {
    bit       is_cfg;
    cfg_reg_t reg_idx;
    int       reg_val;
    in_item_t item;
    bit       typed;
    result_t  want;
  } plan_row_t;

  plan_row_t plan_rows[$];

  function automatic int clamp_side(input logic [SIDE_W-1:0] r);
    return (int'(r) > MAX_SIDE) ? MAX_SIDE : int'(r);
  endfunction

  function automatic result_t next_copy_addr(input in_item_t it);
    int dw, dh, sw, sh, dx, dy, sx, sy, w, h;
    result_t r;
    r = '0;
    r.kind = KIND_NONE;
    dw = clamp_side(map_dst_w);
    dh = clamp_side(map_dst_h);
    sw = clamp_side(map_src_w);
    sh = clamp_side(map_src_h);
    if (it.action == ACT_START) begin
      dx = int'(it.dest_x);
      dy = int'(it.dest_y);
      sx = int'(it.src_x);
      sy = int'(it.src_y);
      w = int'(it.copy_w);
      h = int'(it.copy_h);
      run_on = 1'b0;
      if (dx >= dw || dy >= dh) return r;
      if (dx < 0) begin
        sx -= dx; w += dx; dx = 0;
      end
      if (dx + w > dw) w = dw - dx;
      if (dy < 0) begin
        sy -= dy; h += dy; dy = 0;
      end
      if (dy + h > dh) h = dh - dy;
      if (sx >= sw || sy >= sh) return r;
      if (sx < 0) begin
        dx -= sx; w += sx; sx = 0;
      end
      if (sx + w > sw) w = sw - sx;
      if (sy < 0) begin
        dy -= sy; h += sy; sy = 0;
      end
      if (sy + h > sh) h = sh - sy;
      if (dx >= dw || dy >= dh || w <= 0 || h <= 0) return r;
      src_at = IDX_W'(sy * sw + sx);
      dst_at = IDX_W'(dy * dw + dx);
      row_len = CNT_W'(w);
      cols_to_go = CNT_W'(w - 1);
      rows_to_go = CNT_W'(h - 1);
    end else begin
      if (!run_on) begin
        r.kind = KIND_IDLE;
        return r;
      end
      if (cols_to_go != 0) begin
        src_at = src_at + 1'b1;
        dst_at = dst_at + 1'b1;
        cols_to_go = cols_to_go - 1'b1;
      end else begin
        // row step uses the map widths in force now
        src_at = IDX_W'(int'(src_at) + sw - int'(row_len) + 1);
        dst_at = IDX_W'(int'(dst_at) + dw - int'(row_len) + 1);
        rows_to_go = rows_to_go - 1'b1;
        cols_to_go = row_len - 1'b1;
      end
    end
    run_on = (cols_to_go != 0) || (rows_to_go != 0);
    r.kind = KIND_PAIR;
    r.src_index = src_at;
    r.dst_index = dst_at;
    r.last = !run_on;
    return r;
  endfunction

  function automatic in_item_t make_item(input action_t a, input int dx, input int dy,
                                         input int sx, input int sy, input int w,
                                         input int h);
    in_item_t it;
    it.action = a;
    it.dest_x = 16'(dx);
    it.dest_y = 16'(dy);
    it.src_x = 16'(sx);
    it.src_y = 16'(sy);
    it.copy_w = 16'(w);
    it.copy_h = 16'(h);
    return it;
  endfunction

  function automatic void plan_cfg(input cfg_reg_t idx, input int v);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = v;
    row.item = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan_rows.push_back(row);
  endfunction

  function automatic void plan_item(input in_item_t it);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = REG_DST_WIDTH;
    row.reg_val = 0;
    row.item = it;
    row.typed = 1'b0;
    row.want = '0;
    plan_rows.push_back(row);
  endfunction

  function automatic void plan_check(input in_item_t it, input kind_t k, input int si,
                                     input int di, input bit lst);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.reg_idx = REG_DST_WIDTH;
    row.reg_val = 0;
    row.item = it;
    row.typed = 1'b1;
    row.want.kind = k;
    row.want.src_index = IDX_W'(si);
    row.want.dst_index = IDX_W'(di);
    row.want.last = lst;
    plan_rows.push_back(row);
  endfunction

  function automatic int pick_coord(input int sd);
    case ($urandom_range(2))
      0: return int'($urandom_range(5)) - 3;
      1: return sd - 3 + int'($urandom_range(4));
      default: return int'($urandom_range(sd + 1)) - 1;
    endcase
  endfunction

  function automatic void check_pair(input result_t got);
    result_t want;
    if (pending_pairs.size() == 0) begin
      if (errors < 10)
        $display("unexpected result: kind %0d src %0d dst %0d last %0d",
                 got.kind, got.src_index, got.dst_index, got.last);
      errors++;
    end else begin
      want = pending_pairs.pop_front();
      if (got.kind !== want.kind || got.src_index !== want.src_index ||
          got.dst_index !== want.dst_index || got.last !== want.last) begin
        if (errors < 10)
          $display("mismatch: expected kind %0d src %0d dst %0d last %0d, got kind %0d src %0d dst %0d last %0d",
                   want.kind, want.src_index, want.dst_index, want.last,
                   got.kind, got.src_index, got.dst_index, got.last);
        errors++;
      end
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.kind = kind_t'(m_axis_tuser);
      got.src_index = m_axis_tdata[19:0];
      got.dst_index = m_axis_tdata[39:20];
      got.last = m_axis_tlast;
      check_pair(got);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (int'($urandom_range(99)) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it, input bit typed, input result_t want);
    result_t predicted;
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {it.copy_h, it.copy_w, it.src_y, it.src_x, it.dest_y, it.dest_x};
    s_axis_tuser <= it.action;
    do @(posedge clk); while (!s_axis_tready);
    predicted = next_copy_addr(it);
    pending_pairs.push_back(typed ? want : predicted);
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_map_size(input cfg_reg_t idx, input int v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= SIDE_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DST_WIDTH:  map_dst_w = SIDE_W'(v);
      REG_DST_HEIGHT: map_dst_h = SIDE_W'(v);
      REG_SRC_WIDTH:  map_src_w = SIDE_W'(v);
      REG_SRC_HEIGHT: map_src_h = SIDE_W'(v);
    endcase
    @(posedge clk);
  endtask

  task automatic set_maps(input int dw, input int dh, input int sw, input int sh);
    wait_drain();
    write_map_size(REG_DST_WIDTH, dw);
    write_map_size(REG_DST_HEIGHT, dh);
    write_map_size(REG_SRC_WIDTH, sw);
    write_map_size(REG_SRC_HEIGHT, sh);
  endtask

  task automatic run_phase(input int n_items);
    int sent, left, n_adv;
    bit hold_done, pause_done;
    sent = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;
    while (sent < n_items) begin
      if (!hold_done && sent >= n_items / 3) begin
        hold_done = 1'b1;
        rx_hold = HOLD_CYCLES;
      end
      if (!pause_done && sent >= 2 * n_items / 3) begin
        pause_done = 1'b1;
        wait_drain();
      end
      if ($urandom_range(99) < 70) begin
        send_item(make_item(ACT_START, pick_coord(clamp_side(map_dst_w)),
                            pick_coord(clamp_side(map_dst_h)),
                            pick_coord(clamp_side(map_src_w)),
                            pick_coord(clamp_side(map_src_h)),
                            int'($urandom_range(7)) - 1, int'($urandom_range(7)) - 1),
                  1'b0, '0);
        sent++;
        left = run_on ? int'(rows_to_go) * int'(row_len) + int'(cols_to_go) : 0;
        // cut some runs short so a new start lands mid-run
        n_adv = ($urandom_range(99) < 20) ? int'($urandom_range(left))
                                           : left + int'($urandom_range(2));
        repeat (n_adv) begin
          send_item(make_item(ACT_ADVANCE, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom), 1'b0, '0);
          sent++;
        end
      end else begin
        send_item(make_item(action_t'($urandom_range(1)), $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    // 1x1 maps after reset
    plan_check(make_item(ACT_ADVANCE, -1, -1, -1, -1, -1, -1), KIND_IDLE, 0, 0, 1'b0);
    plan_check(make_item(ACT_START, 0, 0, 0, 0, 1, 1), KIND_PAIR, 0, 0, 1'b1);
    plan_check(make_item(ACT_ADVANCE, 0, 0, 0, 0, 0, 0), KIND_IDLE, 0, 0, 1'b0);
    plan_check(make_item(ACT_START, 0, 0, 0, 0, 32767, 32767), KIND_PAIR, 0, 0, 1'b1);
    plan_check(make_item(ACT_START, 32767, 0, 0, 0, 1, 1), KIND_NONE, 0, 0, 1'b0);
    plan_check(make_item(ACT_START, 0, 0, 32767, 32767, 1, 1), KIND_NONE, 0, 0, 1'b0);
    plan_check(make_item(ACT_START, -32768, -32768, -32768, -32768, 32767, 32767),
               KIND_NONE, 0, 0, 1'b0);
    plan_check(make_item(ACT_START, 0, 0, 0, 0, -32768, -32768), KIND_NONE, 0, 0, 1'b0);
    plan_cfg(REG_DST_WIDTH, 8);
    plan_cfg(REG_DST_HEIGHT, 6);
    plan_cfg(REG_SRC_WIDTH, 5);
    plan_cfg(REG_SRC_HEIGHT, 7);
    plan_item(make_item(ACT_START, 2, 1, 1, 2, 3, 2));
    repeat (5) plan_item(make_item(ACT_ADVANCE, 0, 0, 0, 0, 0, 0));
    plan_check(make_item(ACT_ADVANCE, 0, 0, 0, 0, 0, 0), KIND_IDLE, 0, 0, 1'b0);
    plan_item(make_item(ACT_START, -2, -1, 0, 0, 10, 10));
    repeat (3) plan_item(make_item(ACT_ADVANCE, 0, 0, 0, 0, 0, 0));
    plan_item(make_item(ACT_START, 6, 4, -3, -2, 5, 5));
    plan_check(make_item(ACT_ADVANCE, 0, 0, 0, 0, 0, 0), KIND_IDLE, 0, 0, 1'b0);
    plan_item(make_item(ACT_START, 7, 5, 4, 6, 4, 4));
    plan_item(make_item(ACT_START, 0, 0, 0, 0, 2, 3));
    // resize while that run is still open
    plan_cfg(REG_DST_WIDTH, 0);
    plan_cfg(REG_SRC_WIDTH, 2047);
    repeat (3) plan_item(make_item(ACT_ADVANCE, 0, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_cfg) begin
        wait_drain();
        write_map_size(plan_rows[i].reg_idx, plan_rows[i].reg_val);
      end else begin
        send_item(plan_rows[i].item, plan_rows[i].typed, plan_rows[i].want);
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          tx_idle_pct = 30; rx_idle_pct = 63;
        end
        1: begin
          tx_idle_pct = 63; rx_idle_pct = 30;
        end
        default: begin
          tx_idle_pct = 0; rx_idle_pct = 0;
        end
      endcase
      case (p)
        0: set_maps(1 + $urandom_range(11), 1 + $urandom_range(11),
                    1 + $urandom_range(11), 1 + $urandom_range(11));
        1: set_maps(1024, 1024, 2047, 1024);
        2: set_maps(0, 6, 9, 4);
        3: set_maps(1 + $urandom_range(11), 1 + $urandom_range(11),
                    1 + $urandom_range(11), 1 + $urandom_range(11));
        4: set_maps(1, 1, 1, 1);
        default: set_maps(2047, 2047, 1024, 0);
      endcase
      run_phase(ITEMS_PER_PHASE);
    end

    wait_drain();
    repeat (LATENCY * 4) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
